// ===== src/cst_pkg.sv =====
// Package for the counting semaphore table: sizes, codes, request and response types.
`timescale 1ns / 1ps
package cst_pkg;

   localparam int NUM_SEMAPHORES = 16;
   localparam int QUEUE_DEPTH    = 16;

   localparam int ID_W    = 4;
   localparam int SLOT_W  = $clog2(NUM_SEMAPHORES);
   localparam int LINK_W  = $clog2(NUM_SEMAPHORES + 1);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W  = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH);
   localparam int COUNT_W = 12;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = COUNT_W'(2047);
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = COUNT_W'(-QUEUE_DEPTH);
   localparam logic [LINK_W-1:0]         LINK_NONE = LINK_W'(NUM_SEMAPHORES);

   localparam logic [1:0] CMD_CREATE  = 2'd0;
   localparam logic [1:0] CMD_DESTROY = 2'd1;
   localparam logic [1:0] CMD_WAIT    = 2'd2;
   localparam logic [1:0] CMD_POST    = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_FREE  = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] sem_id;
      logic [9:0] initial_value;
      logic [7:0] process_id;
   } cst_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] allocated_id;
      logic       blocked;
      logic       woken_valid;
      logic [7:0] woken_pid;
   } cst_rsp_type;

   // Map the 4-bit request id onto a slot index of the table.
   function automatic logic [SLOT_W-1:0] to_slot(input logic [ID_W-1:0] id);
      logic [SLOT_W+ID_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, id};
      return wide[SLOT_W-1:0];
   endfunction

   function automatic logic id_in_range(input logic [ID_W-1:0] id);
      logic [LINK_W+ID_W-1:0] wide;
      wide = {{LINK_W{1'b0}}, id};
      return wide < (LINK_W + ID_W)'(NUM_SEMAPHORES);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [PTR_W-1:0]  ptr);
      return ADDR_W'(slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
   endfunction

endpackage

// ===== src/counting_semaphore_table_unit.sv =====
// Counting semaphore table: free list, counts and per-slot wait rings.
`timescale 1ns / 1ps
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  request  | req_valid, req_stall, req_payload | in
//  response | rsp_valid, rsp_stall, rsp_payload | out
//
// The accept cycle of a request issues the wait-ring memory read, and the execute
// cycle updates the count through one adder, and the ring pointers and free list.
// A request is held in execute while the response register is full and stalled.
// Reset is synchronous; it clears the free list chain, its head and the control
// state. Counts, ring pointers and ring entries are valid once a create writes them.
module counting_semaphore_table_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cst_pkg::cst_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cst_pkg::cst_rsp_type rsp_payload
);
   import cst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   cst_req_type req_ff;
   cst_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic signed [COUNT_W-1:0] counts_ff [NUM_SEMAPHORES];
   logic [PTR_W-1:0]          ring_head_ff [NUM_SEMAPHORES];
   logic [PTR_W-1:0]          ring_tail_ff [NUM_SEMAPHORES];
   logic [LINK_W-1:0]         free_links_ff [NUM_SEMAPHORES];
   logic [LINK_W-1:0]         free_head_ff;
   logic [7:0]                wait_mem_ff [NUM_SEMAPHORES * QUEUE_DEPTH];
   logic [7:0]                rd_pid_ff;

   logic                      accept;
   logic                      commit;
   logic [SLOT_W-1:0]         acc_slot;
   logic [SLOT_W-1:0]         slot;
   logic [SLOT_W-1:0]         free_slot;
   logic                      id_ok;
   logic signed [COUNT_W-1:0] count_cur;
   logic signed [COUNT_W-1:0] count_sum;
   logic                      is_post;
   logic                      wait_full;
   logic                      post_ovf;
   logic                      no_free;
   logic [SLOT_W+3:0]         alloc_wide;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && !(rsp_valid_ff && rsp_stall);

   assign acc_slot  = to_slot(req_payload.sem_id);
   assign slot      = to_slot(req_ff.sem_id);
   assign id_ok     = id_in_range(req_ff.sem_id);
   assign free_slot = free_head_ff[SLOT_W-1:0];
   assign no_free   = (free_head_ff >= LINK_NONE);

   // shared count adder: +1 for post, -1 for wait
   assign count_cur = counts_ff[slot];
   assign is_post   = (req_ff.command == CMD_POST);
   assign count_sum = count_cur + (is_post ? COUNT_W'(1) : COUNT_W'(-1));
   assign wait_full = (count_cur == COUNT_MIN);
   assign post_ovf  = (count_cur >= COUNT_MAX);
   assign alloc_wide = {4'b0, free_slot};

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
               rsp_in   = '0;
               case (req_ff.command)
                  CMD_CREATE: begin
                     if (no_free) begin
                        rsp_in.status = STAT_NO_FREE;
                     end else begin
                        rsp_in.allocated_id = alloc_wide[3:0];
                     end
                  end
                  CMD_WAIT: begin
                     if (id_ok) begin
                        if (wait_full) begin
                           rsp_in.status = STAT_FULL;
                        end else begin
                           rsp_in.blocked = count_sum[COUNT_W-1];
                        end
                     end
                  end
                  CMD_POST: begin
                     if (id_ok) begin
                        if (post_ovf) begin
                           rsp_in.status = STAT_OVERFLOW;
                        end else if (count_sum <= 0) begin
                           rsp_in.woken_valid = 1'b1;
                           rsp_in.woken_pid   = rd_pid_ff;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   // free list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            free_links_ff[i] <= LINK_W'(i + 1);
         end
         free_head_ff <= '0;
      end else if (commit) begin
         if (req_ff.command == CMD_CREATE && !no_free) begin
            free_head_ff <= free_links_ff[free_slot];
         end else if (req_ff.command == CMD_DESTROY && id_ok) begin
            free_links_ff[slot] <= free_head_ff;
            free_head_ff        <= LINK_W'(slot);
         end
      end
   end

   // counts and ring pointers
   always_ff @(posedge clock) begin
      if (commit) begin
         case (req_ff.command)
            CMD_CREATE: begin
               if (!no_free) begin
                  counts_ff[free_slot]    <= COUNT_W'(req_ff.initial_value);
                  ring_head_ff[free_slot] <= '0;
                  ring_tail_ff[free_slot] <= '0;
               end
            end
            CMD_WAIT: begin
               if (id_ok && !wait_full) begin
                  counts_ff[slot] <= count_sum;
                  if (count_sum[COUNT_W-1]) begin
                     ring_tail_ff[slot] <= ptr_inc(ring_tail_ff[slot]);
                  end
               end
            end
            CMD_POST: begin
               if (id_ok && !post_ovf) begin
                  counts_ff[slot] <= count_sum;
                  if (count_sum <= 0) begin
                     ring_head_ff[slot] <= ptr_inc(ring_head_ff[slot]);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // wait ring memory: read the head entry on accept, append on a blocking wait
   always_ff @(posedge clock) begin
      if (commit && req_ff.command == CMD_WAIT && id_ok && !wait_full
          && count_sum[COUNT_W-1]) begin
         wait_mem_ff[ring_addr(slot, ring_tail_ff[slot])] <= req_ff.process_id;
      end
      if (accept) begin
         rd_pid_ff <= wait_mem_ff[ring_addr(acc_slot, ring_head_ff[acc_slot])];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== verif/semaphore_response_checker.sv =====
// Checker for the semaphore table: tracks accepted requests, predicts responses and compares.
`timescale 1ns / 1ps
module semaphore_response_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  cst_pkg::cst_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cst_pkg::cst_rsp_type rsp_payload,
   output int                   fail_count,
   output int                   pending_count
);
   import cst_pkg::*;

   logic signed [COUNT_W-1:0] sem_count [NUM_SEMAPHORES];
   logic [7:0]                waiter_pid [NUM_SEMAPHORES*QUEUE_DEPTH];
   logic [PTR_W-1:0]          wake_ptr [NUM_SEMAPHORES];
   logic [PTR_W-1:0]          enqueue_ptr [NUM_SEMAPHORES];
   logic [LINK_W-1:0]         next_free [NUM_SEMAPHORES];
   logic [LINK_W-1:0]         free_top;
   cst_rsp_type               expected_rsp [$];
   int                        mismatches = 0;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Advance the semaphore table by one request and return the response it owes.
   task automatic apply_request(input cst_req_type r, output cst_rsp_type o);
      int slot;
      int next_count;
      o    = '0;
      slot = int'(r.sem_id);
      if (r.command == CMD_CREATE) begin
         if (free_top >= LINK_W'(NUM_SEMAPHORES)) begin
            o.status = STAT_NO_FREE;
         end else begin
            slot              = int'(free_top);
            free_top          = next_free[slot];
            sem_count[slot]   = COUNT_W'(int'(r.initial_value));
            wake_ptr[slot]    = '0;
            enqueue_ptr[slot] = '0;
            o.allocated_id    = 4'(slot);
         end
      end else if (slot < NUM_SEMAPHORES) begin
         case (r.command)
            CMD_DESTROY: begin
               next_free[slot] = free_top;
               free_top        = LINK_W'(slot);
            end
            CMD_WAIT: begin
               next_count = int'(sem_count[slot]) - 1;
               if (next_count < -QUEUE_DEPTH) begin
                  o.status = STAT_FULL;
               end else begin
                  sem_count[slot] = COUNT_W'(next_count);
                  if (next_count < 0) begin
                     waiter_pid[slot*QUEUE_DEPTH + int'(enqueue_ptr[slot])] = r.process_id;
                     enqueue_ptr[slot] =
                        PTR_W'((int'(enqueue_ptr[slot]) + 1) % QUEUE_DEPTH);
                     o.blocked = 1'b1;
                  end
               end
            end
            default: begin
               if (int'(sem_count[slot]) >= int'(COUNT_MAX)) begin
                  o.status = STAT_OVERFLOW;
               end else begin
                  next_count      = int'(sem_count[slot]) + 1;
                  sem_count[slot] = COUNT_W'(next_count);
                  if (next_count <= 0) begin
                     o.woken_pid   = waiter_pid[slot*QUEUE_DEPTH + int'(wake_ptr[slot])];
                     o.woken_valid = 1'b1;
                     wake_ptr[slot] = PTR_W'((int'(wake_ptr[slot]) + 1) % QUEUE_DEPTH);
                  end
               end
            end
         endcase
      end
   endtask

   task automatic check_response(input cst_rsp_type got);
      cst_rsp_type want;
      if (expected_rsp.size() == 0) begin
         flag_mismatch("unrequested response", 1, 0);
         return;
      end
      want = expected_rsp.pop_front();
      if (got.status != want.status) flag_mismatch("status", got.status, want.status);
      if (got.allocated_id != want.allocated_id)
         flag_mismatch("allocated_id", got.allocated_id, want.allocated_id);
      if (got.blocked != want.blocked) flag_mismatch("blocked", got.blocked, want.blocked);
      if (got.woken_valid != want.woken_valid)
         flag_mismatch("woken_valid", got.woken_valid, want.woken_valid);
      if (got.woken_pid != want.woken_pid)
         flag_mismatch("woken_pid", got.woken_pid, want.woken_pid);
   endtask

   always @(posedge clock) begin : track
      cst_rsp_type predicted;
      if (reset) begin
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            next_free[i] = LINK_W'(i + 1);
         end
         free_top = '0;
         expected_rsp.delete();
      end else begin
         // Compare first: a response never belongs to the request taken at the same edge.
         if (rsp_valid && !rsp_stall) check_response(rsp_payload);
         if (req_valid && !req_stall) begin
            apply_request(req_payload, predicted);
            expected_rsp.push_back(predicted);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_rsp.size();
   end

endmodule

// ===== verif/tb_counting_semaphore_table_unit.sv =====
// Testbench top for the semaphore table: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_counting_semaphore_table_unit;
   import cst_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   cst_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   cst_rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int send_idle_pct  = 21;
   int recv_stall_pct = 45;
   int cycle_count    = 0;
   int sent_items     = 0;

   // Free list as seen from the request side; tells which slots a create hands out.
   logic [LINK_W-1:0] mirror_link [NUM_SEMAPHORES];
   logic [LINK_W-1:0] mirror_head;
   bit                was_created [NUM_SEMAPHORES];

   counting_semaphore_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   semaphore_response_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int pick_created();
      int s;
      do s = $urandom_range(0, NUM_SEMAPHORES - 1); while (!was_created[s]);
      return s;
   endfunction

   // Mostly tiny counts so that waits block.
   function automatic int fresh_count();
      return ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 1023);
   endfunction

   task automatic issue(input logic [1:0] cmd, input int slot, input int value, input int pid);
      cst_req_type r;
      r.command       = cmd;
      r.sem_id        = 4'(slot);
      r.initial_value = 10'(value);
      r.process_id    = 8'(pid);
      if (cmd == CMD_CREATE) begin
         if (mirror_head < LINK_W'(NUM_SEMAPHORES)) begin
            was_created[mirror_head] = 1'b1;
            mirror_head              = mirror_link[mirror_head];
         end
      end else if (cmd == CMD_DESTROY) begin
         mirror_link[slot] = mirror_head;
         mirror_head       = LINK_W'(slot);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   // Hold off new requests until every response is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic run_random(input int quota);
      int stop_at;
      int kind;
      int slot;
      int depth;
      logic [1:0] cmd;
      stop_at = sent_items + quota;
      while (sent_items < stop_at) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            // queue some waiters on one semaphore, then post up to one more time than it waited
            slot  = pick_created();
            depth = ($urandom_range(0, 7) == 0) ? $urandom_range(1, QUEUE_DEPTH + 2)
                                                : $urandom_range(1, 5);
            repeat (depth) issue(CMD_WAIT, slot, $urandom_range(0, 1023), $urandom_range(0, 255));
            repeat ($urandom_range(0, depth + 1))
               issue(CMD_POST, slot, $urandom_range(0, 1023), $urandom_range(0, 255));
         end else if (kind < 7) begin
            if (mirror_head < LINK_W'(NUM_SEMAPHORES)) begin
               slot = int'(mirror_head);
               issue(CMD_CREATE, $urandom_range(0, 15), fresh_count(), $urandom_range(0, 255));
               repeat ($urandom_range(0, 4))
                  issue($urandom_range(0, 1) ? CMD_WAIT : CMD_POST, slot,
                        $urandom_range(0, 1023), $urandom_range(0, 255));
               if ($urandom_range(0, 1) == 1)
                  issue(CMD_DESTROY, slot, $urandom_range(0, 1023), $urandom_range(0, 255));
            end else begin
               issue(CMD_DESTROY, $urandom_range(0, 15), $urandom_range(0, 1023),
                     $urandom_range(0, 255));
            end
         end else if (kind < 8) begin
            issue(CMD_DESTROY, $urandom_range(0, 15), $urandom_range(0, 1023),
                  $urandom_range(0, 255));
         end else begin
            // noise: any command, but never wait on or post to a slot that was never created
            cmd  = 2'($urandom_range(0, 3));
            slot = $urandom_range(0, 15);
            if ((cmd == CMD_WAIT || cmd == CMD_POST) && !was_created[slot]) slot = pick_created();
            issue(cmd, slot, (cmd == CMD_CREATE) ? fresh_count() : $urandom_range(0, 1023),
                  $urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_SEMAPHORES; i++) begin
         mirror_link[i] = LINK_W'(i + 1);
         was_created[i] = 1'b0;
      end
      mirror_head = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // exhaust the free list, then one create too many
      for (int i = 0; i < NUM_SEMAPHORES; i++) begin
         issue(CMD_CREATE, $urandom_range(0, 15),
               (i == 0) ? 0 : (i == 1) ? 1023 : (i % 2 == 1) ? 10'h2AA : 10'h155,
               (i % 2 == 1) ? 8'hFF : 8'h00);
      end
      issue(CMD_CREATE, 15, 1023, 8'hFF);
      issue(CMD_WAIT, 0, 0, 8'hFF);
      issue(CMD_WAIT, 0, 1023, 8'h00);
      issue(CMD_POST, 0, 0, 8'h00);
      issue(CMD_POST, 1, 0, 8'h55);
      issue(CMD_WAIT, 15, 0, 8'hAA);
      // destroy with a waiter still queued, then reuse the slot
      issue(CMD_DESTROY, 0, 0, 0);
      issue(CMD_CREATE, 0, 1, 0);
      // double destroy links the slot twice
      issue(CMD_DESTROY, 15, 0, 0);
      issue(CMD_DESTROY, 15, 0, 0);
      issue(CMD_CREATE, 3, 2, 0);
      issue(CMD_CREATE, 3, 0, 0);

      run_random(180);

      // fill one wait ring past its depth, then empty it
      issue(CMD_DESTROY, 6, 0, 0);
      issue(CMD_CREATE, 0, 0, 0);
      repeat (QUEUE_DEPTH + 1) issue(CMD_WAIT, 6, 0, $urandom_range(0, 255));
      repeat (QUEUE_DEPTH + 1) issue(CMD_POST, 6, 0, $urandom_range(0, 255));

      drain();
      send_idle_pct  = 45;
      recv_stall_pct = 21;
      run_random(180);

      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(180);

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
